// ===== rtl/core/xoshiro256_random_generator_unit_defines.svh =====
// ----------------------------------------------------------------------------
// xoshiro256_random_generator_unit_defines.svh
// Assertion macros for the xoshiro256** generator; empty when synthesizing.
// ----------------------------------------------------------------------------
`ifndef XOSHIRO256_RANDOM_GENERATOR_UNIT_DEFINES_SVH
`define XOSHIRO256_RANDOM_GENERATOR_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Check that cond implies prop in the same cycle.
`define XRG_ASSERT_SAME(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Check that cond implies prop in the next cycle.
`define XRG_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`else

`define XRG_ASSERT_SAME(label, clk, rst_n, cond, prop, msg)
`define XRG_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg)

`endif

`endif

// ===== rtl/core/xrg_pkg.sv =====
// ----------------------------------------------------------------------------
// xrg_pkg
// Shared constants, types and helpers of the xoshiro256** generator.
// ----------------------------------------------------------------------------
package xrg_pkg;

    localparam int unsigned WordW      = 64;
    localparam int unsigned NumWords   = 4;
    localparam logic [WordW-1:0] SeedMask = 64'h7a12345fb678ce93;
    localparam int unsigned MixShift   = 17;
    localparam int unsigned MixRot     = 45;
    localparam int unsigned ScrRot     = 7;
    localparam int unsigned WarmupRuns = 6;
    localparam int unsigned FillBase   = 2;
    localparam int unsigned WarmCntW   = $clog2(WarmupRuns);
    localparam logic [WarmCntW-1:0] WarmLast = WarmCntW'(WarmupRuns - 1);

    // action codes
    localparam logic ActDraw = 1'b0;
    localparam logic ActSeed = 1'b1;

    typedef logic [WordW-1:0] word_t;

    typedef enum logic [1:0] {
        ST_INIT,
        ST_IDLE,
        ST_WARM
    } ctrl_state_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;       // fill the state from a seed
        logic seed_zero;  // use a zero seed for the fill
        logic advance;    // run one mix step
        logic capture;    // latch the scrambled output word
    } dp_cmd_t;

    // rotate left by a fixed amount in 1..WordW-1
    function automatic word_t rot_left(input word_t v, input int unsigned r);
        rot_left = (v << r) | (v >> (WordW - r));
    endfunction

endpackage

// ===== rtl/core/xoshiro256_random_generator_unit.sv =====
// ----------------------------------------------------------------------------
// xoshiro256_random_generator_unit
// xoshiro256** pseudo-random word source with masked seeding and warm-up.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): each item carries action and
//   seed_value. A draw item (action 0) yields one 64-bit random_word; a
//   seed item (action 1) reloads the 256-bit state and yields nothing.
//   Output channel (out_valid / out_stall): one item per draw, in order.
// Draw and seed items:
//   A draw result appears in the output register the cycle after the item
//   is taken; draws are taken one per cycle while no warm-up runs and no
//   result is held by out_stall, since the scrambler works from a
//   word-1-times-five register kept in step with the state. A seed item fills
//   the state at acceptance, then six mix steps run with in_stall high.
// Reset:
//   The state is filled as for a zero seed and then warmed up;
//   in_stall is high until that is done.
// Stall:
//   While out_stall holds a waiting result, in_stall rises and no new item
//   is taken; the held word does not change.
// ----------------------------------------------------------------------------
`include "xoshiro256_random_generator_unit_defines.svh"

module xoshiro256_random_generator_unit
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  action,
    input  logic [63:0]           seed_value,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [63:0]           random_word
);

    // command bundle from the controller to the datapath
    xrg_pkg::dp_cmd_t cmd;

    // sequence handshakes, reset warm-up and reseed warm-up
    xrg_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .action    (action),
        .out_stall (out_stall),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .cmd       (cmd)
    );

    // hold the state words and produce the scrambled word
    xrg_datapath u_datapath
    (
        .clk         (clk),
        .cmd         (cmd),
        .seed_value  (seed_value),
        .random_word (random_word)
    );

    // a taken draw shows its result in the next cycle
    `XRG_ASSERT_NEXT(a_draw_result, clk, rst_n,
        in_valid && !in_stall && action == xrg_pkg::ActDraw, out_valid,
        "draw item taken without a result")

    // a taken seed item blocks input during warm-up
    `XRG_ASSERT_NEXT(a_seed_busy, clk, rst_n,
        in_valid && !in_stall && action == xrg_pkg::ActSeed, in_stall,
        "input taken during warm-up")

    // an item is taken only when the output register is free or draining
    `XRG_ASSERT_SAME(a_out_free, clk, rst_n,
        in_valid && !in_stall, !out_valid || !out_stall,
        "item taken while a result is held")

endmodule

// ===== rtl/core/xrg_ctrl.sv =====
// ----------------------------------------------------------------------------
// xrg_ctrl
// Controller: input and output handshake, warm-up sequencing.
// ----------------------------------------------------------------------------
module xrg_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic            action,
    input  logic            out_stall,
    output logic            in_stall,
    output logic            out_valid,
    output xrg_pkg::dp_cmd_t cmd
);

    xrg_pkg::ctrl_state_t state_reg, state_next;
    logic [xrg_pkg::WarmCntW-1:0] cnt_reg, cnt_next;
    logic out_valid_reg, out_valid_next;
    logic accept;

    assign in_stall  = (state_reg != xrg_pkg::ST_IDLE) || (out_valid_reg && out_stall);
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            xrg_pkg::ST_INIT:
                state_next = xrg_pkg::ST_WARM;
            xrg_pkg::ST_IDLE:
                if (accept && action == xrg_pkg::ActSeed)
                    state_next = xrg_pkg::ST_WARM;
            xrg_pkg::ST_WARM:
                if (cnt_reg == xrg_pkg::WarmLast)
                    state_next = xrg_pkg::ST_IDLE;
            default:
                state_next = xrg_pkg::ST_INIT;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd      = '0;
        cnt_next = '0;
        case (state_reg)
            xrg_pkg::ST_INIT:
            begin
                cmd.load      = 1'b1;
                cmd.seed_zero = 1'b1;
            end
            xrg_pkg::ST_IDLE:
                if (accept)
                begin
                    if (action == xrg_pkg::ActSeed)
                        cmd.load = 1'b1;
                    else
                    begin
                        cmd.advance = 1'b1;
                        cmd.capture = 1'b1;
                    end
                end
            xrg_pkg::ST_WARM:
            begin
                cmd.advance = 1'b1;
                cnt_next    = cnt_reg + 1'b1;
            end
            default:
                cmd = '0;
        endcase
    end

    // hold a result until taken
    always_comb
    begin
        if (cmd.capture)
            out_valid_next = 1'b1;
        else if (out_stall)
            out_valid_next = out_valid_reg;
        else
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= xrg_pkg::ST_INIT;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== rtl/core/xrg_datapath.sv =====
// ----------------------------------------------------------------------------
// xrg_datapath
// Datapath: state words, seed fill, mix step and output scrambler.
// ----------------------------------------------------------------------------
module xrg_datapath
(
    input  logic             clk,
    input  xrg_pkg::dp_cmd_t cmd,
    input  xrg_pkg::word_t   seed_value,
    output xrg_pkg::word_t   random_word
);

    xrg_pkg::word_t gen_reg  [xrg_pkg::NumWords];
    xrg_pkg::word_t gen_next [xrg_pkg::NumWords];
    xrg_pkg::word_t mul5_reg, mul5_next;   // word 1 times five, kept in step
    xrg_pkg::word_t word_reg, word_next;

    xrg_pkg::word_t seed_src, seed_mixed;
    xrg_pkg::word_t fill [xrg_pkg::NumWords];
    xrg_pkg::word_t mix  [xrg_pkg::NumWords];
    xrg_pkg::word_t x2, x3, scr_rot;

    assign seed_src   = cmd.seed_zero ? '0 : seed_value;
    assign seed_mixed = seed_src ^ xrg_pkg::SeedMask;

    always_comb
    begin
        for (int i = 0; i < xrg_pkg::NumWords; i++)
            fill[i] = seed_mixed ^ (seed_mixed << (i + xrg_pkg::FillBase));
    end

    // one mix step
    always_comb
    begin
        x2     = gen_reg[2] ^ gen_reg[0];
        x3     = gen_reg[3] ^ gen_reg[1];
        mix[1] = gen_reg[1] ^ x2;
        mix[0] = gen_reg[0] ^ x3;
        mix[2] = x2 ^ (gen_reg[1] << xrg_pkg::MixShift);
        mix[3] = xrg_pkg::rot_left(x3, xrg_pkg::MixRot);
    end

    always_comb
    begin
        for (int i = 0; i < xrg_pkg::NumWords; i++)
            gen_next[i] = gen_reg[i];
        if (cmd.load)
        begin
            for (int i = 0; i < xrg_pkg::NumWords; i++)
                gen_next[i] = fill[i];
        end
        else if (cmd.advance)
        begin
            for (int i = 0; i < xrg_pkg::NumWords; i++)
                gen_next[i] = mix[i];
        end
        mul5_next = gen_next[1] + (gen_next[1] << 2);
    end

    // scramble: rotl(word1 * 5, 7) * 9, taken before the update
    assign scr_rot   = xrg_pkg::rot_left(mul5_reg, xrg_pkg::ScrRot);
    assign word_next = cmd.capture ? (scr_rot + (scr_rot << 3)) : word_reg;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < xrg_pkg::NumWords; i++)
            gen_reg[i] <= gen_next[i];
        mul5_reg <= mul5_next;
        word_reg <= word_next;
    end

    assign random_word = word_reg;

endmodule
